// ===== hw/rtl/u8v_pkg.sv =====
// Shared types and constants for the UTF-8 stream validator.
// No dependencies; imported by every module of the block.
package u8v_pkg;

  localparam int U8V_FIFO_DEPTH = 4;
  localparam int CP_W           = 21;

  localparam logic [CP_W-1:0] CP_MIN2 = CP_W'(32'h80);
  localparam logic [CP_W-1:0] CP_MIN3 = CP_W'(32'h800);
  localparam logic [CP_W-1:0] CP_MIN4 = CP_W'(32'h10000);
  localparam logic [CP_W-1:0] CP_MAX  = CP_W'(32'h10ffff);
  localparam logic [CP_W-1:0] SUR_LO  = CP_W'(32'hd800);
  localparam logic [CP_W-1:0] SUR_HI  = CP_W'(32'hdfff);

  localparam logic [2:0] LEN1 = 3'd1;
  localparam logic [2:0] LEN2 = 3'd2;
  localparam logic [2:0] LEN3 = 3'd3;
  localparam logic [2:0] LEN4 = 3'd4;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } u8v_cls_t;

  typedef struct packed {
    u8v_cls_t   cls;
    logic [6:0] bits;
    logic       last;
  } u8v_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u8v_fifo_stat_t;

endpackage

// ===== hw/rtl/u8v_front.sv =====
// Front end: takes input bytes and classifies each one for the queue.
// Depends on u8v_pkg.
module u8v_front
  import u8v_pkg::*;
(
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic           s_tlast,
  input  u8v_fifo_stat_t stat,
  output logic           push,
  output u8v_entry_t     entry
);

  u8v_cls_t cls;

  always_comb begin
    priority casez (s_tdata)
      8'b0???????: cls = CLS_ASCII;
      8'b10??????: cls = CLS_CONT;
      8'b110?????: cls = CLS_LEAD2;
      8'b1110????: cls = CLS_LEAD3;
      8'b11110???: cls = CLS_LEAD4;
      default:     cls = CLS_BAD;
    endcase
  end

  always_comb begin
    entry.cls  = cls;
    entry.last = s_tlast;
    unique case (cls)
      CLS_ASCII: entry.bits = s_tdata[6:0];
      CLS_LEAD2: entry.bits = {2'b00, s_tdata[4:0]};
      CLS_LEAD3: entry.bits = {3'b000, s_tdata[3:0]};
      CLS_LEAD4: entry.bits = {4'b0000, s_tdata[2:0]};
      CLS_CONT:  entry.bits = {1'b0, s_tdata[5:0]};
      default:   entry.bits = '0;
    endcase
  end

  assign s_tready = !stat.full;
  assign push     = s_tvalid && !stat.full;

endmodule

// ===== hw/rtl/u8v_fifo.sv =====
// Short queue of classified bytes between front and back end.
// Depends on u8v_pkg.
module u8v_fifo
  import u8v_pkg::*;
#(
  parameter int DEPTH = U8V_FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  u8v_entry_t     wr_entry,
  input  logic           pop,
  output u8v_entry_t     rd_entry,
  output u8v_fifo_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8v_entry_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_entry   = mem[rd_ptr];
  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== hw/rtl/u8v_back.sv =====
// Back end: decodes queued bytes, checks code points, registers the verdict.
// Depends on u8v_pkg.
module u8v_back
  import u8v_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  u8v_entry_t     entry,
  input  u8v_fifo_stat_t stat,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata
);

  logic [1:0]      bytes_pending;
  logic [2:0]      sequence_length;
  logic [CP_W-1:0] code_point_acc;
  logic            error_seen;
  logic            string_valid;

  logic [1:0]      bytes_pending_next;
  logic [2:0]      sequence_length_next;
  logic [CP_W-1:0] code_point_acc_next;
  logic            error_seen_next;
  logic [CP_W-1:0] cp_shifted;
  logic            cp_bad;

  assign pop = !stat.empty && (!m_tvalid || m_tready);

  assign cp_shifted = {code_point_acc[CP_W-7:0], entry.bits[5:0]};

  always_comb begin
    unique case (sequence_length)
      LEN2:    cp_bad = cp_shifted < CP_MIN2;
      LEN3:    cp_bad = cp_shifted < CP_MIN3;
      LEN4:    cp_bad = cp_shifted < CP_MIN4;
      default: cp_bad = 1'b0;
    endcase
    if (cp_shifted > CP_MAX) begin
      cp_bad = 1'b1;
    end
    if (cp_shifted >= SUR_LO && cp_shifted <= SUR_HI) begin
      cp_bad = 1'b1;
    end
  end

  always_comb begin
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    code_point_acc_next  = code_point_acc;
    error_seen_next      = error_seen;
    if (!error_seen) begin
      if (bytes_pending == 2'd0) begin
        unique case (entry.cls)
          CLS_ASCII: begin
            sequence_length_next = LEN1;
            code_point_acc_next  = CP_W'(entry.bits);
          end
          CLS_LEAD2: begin
            sequence_length_next = LEN2;
            code_point_acc_next  = CP_W'(entry.bits);
            bytes_pending_next   = 2'd1;
          end
          CLS_LEAD3: begin
            sequence_length_next = LEN3;
            code_point_acc_next  = CP_W'(entry.bits);
            bytes_pending_next   = 2'd2;
          end
          CLS_LEAD4: begin
            sequence_length_next = LEN4;
            code_point_acc_next  = CP_W'(entry.bits);
            bytes_pending_next   = 2'd3;
          end
          default: begin
            error_seen_next = 1'b1;
          end
        endcase
      end else if (entry.cls != CLS_CONT) begin
        error_seen_next    = 1'b1;
        bytes_pending_next = 2'd0;
      end else begin
        code_point_acc_next = cp_shifted;
        bytes_pending_next  = bytes_pending - 2'd1;
        if (bytes_pending_next == 2'd0 && cp_bad) begin
          error_seen_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending   <= '0;
      sequence_length <= '0;
      code_point_acc  <= '0;
      error_seen      <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (pop && entry.last) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        if (entry.last) begin
          bytes_pending   <= '0;
          sequence_length <= '0;
          code_point_acc  <= '0;
          error_seen      <= 1'b0;
        end else begin
          bytes_pending   <= bytes_pending_next;
          sequence_length <= sequence_length_next;
          code_point_acc  <= code_point_acc_next;
          error_seen      <= error_seen_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      string_valid <= !error_seen_next && (bytes_pending_next == 2'd0);
    end
  end

  assign m_tdata = {7'b0, string_valid};

endmodule

// ===== hw/rtl/utf8_stream_validator.sv =====
// Top level of the UTF-8 stream validator: front end, queue, back end.
// Depends on u8v_pkg, u8v_front, u8v_fifo, u8v_back.
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tdata = data_byte, s_tlast = end_of_string
// m_*       out  m_tvalid/m_tready   m_tdata[0] = string_valid
//
// One item per cycle sustained while the output is not stalled; a byte is
// stored in the queue before it decodes, and a verdict is shown in the cycle after
// its final byte decodes. The back end updates decode state once per popped byte.
// Synchronous reset clears the queue, decode state and output valid.
// A stalled output holds the verdict; the queue of FIFO_DEPTH items keeps
// input flowing until it fills.
module utf8_stream_validator
  import u8v_pkg::*;
#(
  parameter int FIFO_DEPTH = U8V_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] string_valid, [7:1] zero
);

  u8v_fifo_stat_t stat;
  u8v_entry_t     wr_entry;
  u8v_entry_t     rd_entry;
  logic           push;
  logic           pop;

  u8v_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .stat     (stat),
    .push     (push),
    .entry    (wr_entry)
  );

  u8v_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .stat     (stat)
  );

  u8v_back u_back (
    .clk      (clk),
    .rst      (rst),
    .entry    (rd_entry),
    .stat     (stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_stat_sane: assert property (@(posedge clk) disable iff (rst)
    !(stat.full && stat.empty))
    else $error("queue both full and empty");

  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!m_tvalid || m_tready))
    else $error("decode while verdict blocked");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (pop && rd_entry.last) |=> m_tvalid)
    else $error("final byte gave no verdict");
`endif

endmodule
